>>> rtl/rths_pkg.sv
// Package for the relay tap hysteresis selector.
// Holds level/voltage types, threshold tables and the relay mask table.
// No dependencies.
`timescale 1ns / 1ps

package rths_pkg;

    localparam int VOLT_W     = 12;
    localparam int LEVEL_W    = 3;
    localparam int MASK_W     = 3;
    localparam int NUM_LEVELS = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    typedef logic [VOLT_W-1:0]  volt_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [MASK_W-1:0]  mask_t;

    localparam level_t LEVEL_RESET = 3'd4;
    localparam level_t LEVEL_TOP   = 3'd5;
    localparam level_t LEVEL_FAIL  = 3'd0;

    // Up-thresholds in 0.1 V, index is the target level; entry 0 is unused.
    localparam volt_t UP_THR [NUM_LEVELS] = '{
        12'd0, 12'd1728, 12'd1901, 12'd2022, 12'd2225, 12'd2461
    };
    // Down-thresholds in 0.1 V, index is the target level; entry 5 is unused.
    localparam volt_t DN_THR [NUM_LEVELS] = '{
        12'd1652, 12'd1757, 12'd1934, 12'd2139, 12'd2353, 12'd0
    };

    // Decision handed from the selector to the result register.
    typedef struct packed {
        mask_t  relay_mask;
        level_t tap_level;
    } rths_decision_t;

    // Relay drive per level: bit0 relay1, bit1 relay2, bit2 relay3.
    function automatic mask_t relay_of_level(input level_t lvl);
        mask_t m;
        unique case (lvl)
            3'd0:    m = 3'b000;
            3'd1:    m = 3'b100;
            3'd2:    m = 3'b001;
            3'd3:    m = 3'b101;
            3'd4:    m = 3'b011;
            3'd5:    m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/rths_select.sv
// Next-level decision for the relay tap selector: ten constant compares.
// Depends on rths_pkg.
`timescale 1ns / 1ps

module rths_select (
    input  rths_pkg::level_t         level,
    input  rths_pkg::volt_t          voltage_tenths,
    output rths_pkg::rths_decision_t decision
);
    import rths_pkg::*;

    level_t up_level;
    level_t dn_level;
    logic   up_hit;
    logic   dn_hit;

    // Highest level above the current one whose up-threshold is exceeded.
    always_comb
    begin
        up_level = level;
        up_hit   = 1'b0;
        for (int k = 1; k < NUM_LEVELS; k++)
        begin
            if ((LEVEL_W'(k) > level) && (voltage_tenths > UP_THR[k]))
            begin
                up_level = LEVEL_W'(k);
                up_hit   = 1'b1;
            end
        end
    end

    // Lowest level below the current one whose down-threshold is undercut.
    always_comb
    begin
        dn_level = level;
        dn_hit   = 1'b0;
        for (int k = NUM_LEVELS - 2; k >= 0; k--)
        begin
            if ((LEVEL_W'(k) < level) && (voltage_tenths < DN_THR[k]))
            begin
                dn_level = LEVEL_W'(k);
                dn_hit   = 1'b1;
            end
        end
    end

    always_comb
    begin
        decision.relay_mask = relay_of_level(level);
        priority if (level > LEVEL_TOP)
            decision.tap_level = LEVEL_FAIL;
        else if (up_hit)
            decision.tap_level = up_level;
        else if (dn_hit)
            decision.tap_level = dn_level;
        else
            decision.tap_level = level;
    end

endmodule

>>> rtl/relay_tap_hysteresis_selector_core.sv
// Channel  Dir  Width  Fields (low bit first)
// s_axis   in   16     voltage_tenths[11:0], zero pad[15:12]
// m_axis   out  8      relay_mask[2:0], tap_level[5:3], zero pad[7:6]
//
// One item per clock unless m_axis stalls; stages: input register, result register.
// The tap level register updates as an item moves from the input to the result register.
// Reset (rst_n low, async) clears both valid flags and sets the tap level to 4.
// A stall on m_axis holds the result; the input register still takes an item while
// the result register is free or being drained in the same cycle.
// Depends on rths_pkg and rths_select.
`timescale 1ns / 1ps

module relay_tap_hysteresis_selector_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rths_pkg::S_TDATA_W-1:0] s_tdata,   // voltage_tenths[11:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rths_pkg::M_TDATA_W-1:0] m_tdata    // relay_mask[2:0], tap_level[5:3]
);
    import rths_pkg::*;

    logic           in_valid_reg;
    logic           in_valid_next;
    volt_t          in_volt_reg;
    logic           out_valid_reg;
    logic           out_valid_next;
    rths_decision_t out_reg;
    level_t         level_reg;
    level_t         level_next;
    rths_decision_t decision;
    logic           advance;

    rths_select u_select (
        .level          (level_reg),
        .voltage_tenths (in_volt_reg),
        .decision       (decision)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);
    assign level_next     = advance ? decision.tap_level : level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= LEVEL_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_volt_reg <= s_tdata[VOLT_W-1:0];
        if (advance)
            out_reg <= decision;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - MASK_W - LEVEL_W){1'b0}},
                       out_reg.tap_level, out_reg.relay_mask};

    // Level never leaves the legal range.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_TOP)
        else $error("tap level out of range");

    // Level moves only when an item is decided.
    a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(level_reg))
        else $error("tap level changed without an item");

    // Result level matches the tap level register after each decision.
    a_result_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.tap_level == level_reg))
        else $error("result level differs from held level");

endmodule
